### hw/rtl/dmng_pkg.sv
// Shared types, widths and microcode ROM for the division magic number generator.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package dmng_pkg;

    localparam int DIVISOR_W = 32;
    localparam int LANE_W    = 33;   // lane divisor and remainder
    localparam int QUO_W     = 36;   // lane quotient
    localparam int MAGIC_W   = 36;
    localparam int SHIFT_W   = 6;
    localparam int PC_W      = 4;
    localparam int CNT_W     = 6;

    localparam logic [LANE_W-1:0]  TWO32       = {1'b1, {(LANE_W-1){1'b0}}};
    localparam logic [CNT_W-1:0]   DIV_STEPS   = CNT_W'(32);
    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = SHIFT_W'(32);

    typedef logic [PC_W-1:0] t_upc;

    // microprogram addresses
    localparam t_upc A_WAIT  = 4'd0;
    localparam t_upc A_CHKZ  = 4'd1;
    localparam t_upc A_DIV2A = 4'd2;
    localparam t_upc A_DIV2B = 4'd3;
    localparam t_upc A_ANC   = 4'd4;
    localparam t_upc A_DIV1A = 4'd5;
    localparam t_upc A_DIV1B = 4'd6;
    localparam t_upc A_SRCH  = 4'd7;
    localparam t_upc A_TEST  = 4'd8;
    localparam t_upc A_DONE  = 4'd9;

    typedef enum logic [2:0] {
        J_NEXT,     // fall through
        J_ALWAYS,
        J_IDLE,     // jump while no request
        J_ZERO,     // jump on zero divisor
        J_CNT,      // decrement step counter, jump until last step
        J_SEARCH    // jump while the search must go on
    } t_jcond;

    typedef struct packed {
        t_jcond jcond;
        t_upc   jaddr;
        logic   load_div;
        logic   lane1_clr;
        logic   lane1_step;
        logic   lane2_clr;
        logic   lane2_step;
        logic   bit_one;
        logic   cnt_load;
        logic   anc_load;
        logic   shift_clr;
        logic   shift_inc;
        logic   out_fire;
    } t_uword;

    typedef struct packed {
        logic start;
        logic zero;
        logic search_go;
    } t_status;

    function automatic t_uword f_ucode(input t_upc pc);
        t_uword w;
        w = '0;
        w.jcond = J_NEXT;
        w.jaddr = A_WAIT;
        unique case (pc)
            A_WAIT: begin
                w.jcond    = J_IDLE;
                w.jaddr    = A_WAIT;
                w.load_div = 1'b1;
            end
            A_CHKZ: begin
                w.jcond     = J_ZERO;
                w.jaddr     = A_DONE;
                w.lane2_clr = 1'b1;
            end
            A_DIV2A: begin
                w.lane2_step = 1'b1;
                w.bit_one    = 1'b1;
                w.cnt_load   = 1'b1;
            end
            A_DIV2B: begin
                w.jcond      = J_CNT;
                w.jaddr      = A_DIV2B;
                w.lane2_step = 1'b1;
            end
            A_ANC: begin
                w.anc_load  = 1'b1;
                w.lane1_clr = 1'b1;
                w.shift_clr = 1'b1;
            end
            A_DIV1A: begin
                w.lane1_step = 1'b1;
                w.bit_one    = 1'b1;
                w.cnt_load   = 1'b1;
            end
            A_DIV1B: begin
                w.jcond      = J_CNT;
                w.jaddr      = A_DIV1B;
                w.lane1_step = 1'b1;
            end
            A_SRCH: begin
                w.lane1_step = 1'b1;
                w.lane2_step = 1'b1;
                w.shift_inc  = 1'b1;
            end
            A_TEST: begin
                w.jcond = J_SEARCH;
                w.jaddr = A_SRCH;
            end
            A_DONE: begin
                w.jcond    = J_ALWAYS;
                w.jaddr    = A_WAIT;
                w.out_fire = 1'b1;
            end
            default: begin
                w.jcond = J_ALWAYS;
                w.jaddr = A_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/dmng_lane.sv
// One restoring divide lane: shift a bit into the remainder, compare, subtract.
// Depends on dmng_pkg for lane widths.
`timescale 1ns / 1ps

module dmng_lane (
    input  logic                          i_clk,
    input  logic                          i_clr,
    input  logic                          i_step,
    input  logic                          i_bit,
    input  logic [dmng_pkg::LANE_W-1:0]   i_divisor,
    output logic [dmng_pkg::QUO_W-1:0]    o_quo,
    output logic [dmng_pkg::LANE_W-1:0]   o_rem
);
    import dmng_pkg::*;

    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [LANE_W-1:0] r_rem, n_rem;
    logic [LANE_W:0]   shifted;
    logic              ge;

    always_comb begin
        shifted = {r_rem, i_bit};
        ge      = shifted >= {1'b0, i_divisor};
        n_quo   = r_quo;
        n_rem   = r_rem;
        if (i_clr) begin
            n_quo = '0;
            n_rem = '0;
        end else if (i_step) begin
            n_quo = {r_quo[QUO_W-2:0], ge};
            n_rem = ge ? LANE_W'(shifted - {1'b0, i_divisor}) : LANE_W'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_quo = r_quo;
    assign o_rem = r_rem;

endmodule

### hw/rtl/dmng_sequencer.sv
// Microcode sequencer: program counter, control ROM lookup, step counter, jumps.
// Depends on dmng_pkg for the control word, status struct and ROM function.
`timescale 1ns / 1ps

module dmng_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dmng_pkg::t_status i_status,
    output dmng_pkg::t_uword  o_uword,
    output logic              o_busy
);
    import dmng_pkg::*;

    t_upc             r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_uword           uw;
    logic             taken;

    always_comb begin
        uw    = f_ucode(r_pc);
        n_cnt = r_cnt;
        if (uw.cnt_load) begin
            n_cnt = DIV_STEPS;
        end else if (uw.jcond == J_CNT) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
        unique case (uw.jcond)
            J_NEXT:   taken = 1'b0;
            J_ALWAYS: taken = 1'b1;
            J_IDLE:   taken = !i_status.start;
            J_ZERO:   taken = i_status.zero;
            J_CNT:    taken = r_cnt != CNT_W'(1);
            J_SEARCH: taken = i_status.search_go;
            default:  taken = 1'b1;
        endcase
        n_pc = taken ? uw.jaddr : t_upc'(r_pc + t_upc'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= A_WAIT;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

    assign o_uword = uw;
    assign o_busy  = r_pc != A_WAIT;

endmodule

### hw/rtl/division_magic_number_generator_core.sv
// Top level: divisor registers, two divide lanes, search test and result registers.
// Depends on dmng_pkg, dmng_lane and dmng_sequencer.
//
//  port                 dir  width  role
//  start / busy         in/out 1    request handshake, taken when start && !busy
//  i_divisor            in   32 s   divisor of the request
//  o_done               out  1      result strobe, one cycle
//  o_magic_multiplier   out  36 s   multiplier, meaningful with o_done
//  o_post_shift         out  6      shift, meaningful with o_done
//  o_divisor_valid      out  1      low for a zero divisor
//
// A request runs two 33-step restoring divisions and then a search of 1 to 32
// steps on the shared divide lanes before o_done; a zero divisor goes straight
// from the zero check to the result strobe.
// Reset is synchronous, active low, and returns the sequencer to waiting.
// busy stays high from the request to the strobe; o_done is never held off.
`timescale 1ns / 1ps

module division_magic_number_generator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [dmng_pkg::DIVISOR_W-1:0] i_divisor,
    output logic                                 o_done,
    output logic signed [dmng_pkg::MAGIC_W-1:0]  o_magic_multiplier,
    output logic        [dmng_pkg::SHIFT_W-1:0]  o_post_shift,
    output logic                                 o_divisor_valid
);
    import dmng_pkg::*;

    t_uword  uw;
    t_status status;

    logic [DIVISOR_W-1:0] r_ad;
    logic                 r_neg;
    logic                 r_zero;
    logic [LANE_W-1:0]    r_anc;
    logic [SHIFT_W-1:0]   r_shift;
    logic                 r_done;
    logic [MAGIC_W-1:0]   r_magic;
    logic [SHIFT_W-1:0]   r_post_shift;
    logic                 r_valid;

    logic [QUO_W-1:0]     q1, q2;
    logic [LANE_W-1:0]    r1, r2;
    logic [LANE_W-1:0]    ad_ext, anc_sub, anc_new;
    logic [QUO_W:0]       sum;
    logic [QUO_W:0]       ad_cmp;
    logic                 search_lt, search_eq;
    logic [DIVISOR_W-1:0] raw;

    dmng_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_uword  (uw),
        .o_busy   (busy)
    );

    // lane 1 divides against anc, lane 2 against |d|
    dmng_lane u_lane1 (
        .i_clk     (i_clk),
        .i_clr     (uw.lane1_clr),
        .i_step    (uw.lane1_step),
        .i_bit     (uw.bit_one),
        .i_divisor (r_anc),
        .o_quo     (q1),
        .o_rem     (r1)
    );

    dmng_lane u_lane2 (
        .i_clk     (i_clk),
        .i_clr     (uw.lane2_clr),
        .i_step    (uw.lane2_step),
        .i_bit     (uw.bit_one),
        .i_divisor (ad_ext),
        .o_quo     (q2),
        .o_rem     (r2)
    );

    always_comb begin
        raw    = DIVISOR_W'(i_divisor);
        ad_ext = {1'b0, r_ad};
        // positive: (2^32-1) - ((2^32-1) mod |d|), negative: 2^32 - (2^32 mod |d|)
        anc_sub = (!r_neg && r2 == '0) ? ad_ext : r2;
        anc_new = TWO32 - anc_sub;
        // q1 < |d| - r2  <=>  q1 + r2 < |d|
        sum       = {1'b0, q1} + (QUO_W + 1)'(r2);
        ad_cmp    = (QUO_W + 1)'(r_ad);
        search_lt = sum < ad_cmp;
        search_eq = sum == ad_cmp;
        status.start     = start;
        status.zero      = r_zero;
        status.search_go = (search_lt || (search_eq && r1 == '0))
                           && r_shift != SHIFT_LIMIT;
    end

    always_ff @(posedge i_clk) begin
        if (uw.load_div && start) begin
            r_neg  <= raw[DIVISOR_W-1];
            r_zero <= raw == '0;
            r_ad   <= raw[DIVISOR_W-1] ? DIVISOR_W'(~raw + DIVISOR_W'(1)) : raw;
        end
        if (uw.anc_load) begin
            r_anc <= anc_new;
        end
        if (uw.shift_clr) begin
            r_shift <= '0;
        end else if (uw.shift_inc) begin
            r_shift <= r_shift + SHIFT_W'(1);
        end
        if (uw.out_fire) begin
            if (r_zero) begin
                r_magic      <= '0;
                r_post_shift <= '0;
                r_valid      <= 1'b0;
            end else begin
                // -(q2 + 1) is ~q2
                r_magic      <= r_neg ? ~q2 : q2 + QUO_W'(1);
                r_post_shift <= r_shift;
                r_valid      <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= uw.out_fire;
        end
    end

    assign o_done             = r_done;
    assign o_magic_multiplier = signed'(r_magic);
    assign o_post_shift       = r_post_shift;
    assign o_divisor_valid    = r_valid;

`ifndef SYNTH
    a_done_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_busy_after_req : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted without going busy");

    a_zero_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_divisor_valid |-> o_magic_multiplier == '0 && o_post_shift == '0)
        else $error("zero divisor result not cleared");

    a_shift_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_divisor_valid |-> o_post_shift != '0 && o_post_shift <= SHIFT_LIMIT)
        else $error("post shift out of range");
`endif

endmodule
